// ----- rtl/threshold_palette_builder_unit_defines.svh -----
// Assertion macros for the checker file.
`ifndef THRESHOLD_PALETTE_BUILDER_UNIT_DEFINES_SVH
`define THRESHOLD_PALETTE_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TPB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tpb_pkg.sv -----
`default_nettype none

package tpb_pkg;

    localparam int PALETTE_DEPTH = 64;
    localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    // fixed result field widths
    localparam int MATCH_W = 6;
    localparam int COUNT_W = 7;

    localparam int CHAN_W = 8;
    localparam int THR_W  = 9;
    localparam logic [THR_W-1:0] THR_RESET = 9'd25;

    // APB register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_THRESHOLD = '0;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } colour_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             hold;
        logic             append;
        logic [THR_W-1:0] threshold;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/tpb_cell.sv -----
`default_nettype none

// One palette slot plus one stage of the request chain.
module tpb_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tpb_pkg::cell_ctrl_t ctrl,
    input  wire logic                in_valid,
    input  wire tpb_pkg::colour_t    in_colour,
    input  wire logic                filled,
    output logic                     out_valid,
    output tpb_pkg::colour_t         out_colour,
    output logic                     hit
);
    import tpb_pkg::*;

    logic    tok_valid_reg;
    logic    tok_valid_next;
    colour_t tok_colour_reg;
    colour_t entry_reg;

    logic [CHAN_W-1:0] dr;
    logic [CHAN_W-1:0] dg;
    logic [CHAN_W-1:0] db;
    logic              similar;

    assign tok_valid_next = in_valid | (tok_valid_reg & ctrl.hold);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tok_valid_reg <= 1'b0;
        end
        else begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid) begin
            tok_colour_reg <= in_colour;
        end
        if (tok_valid_reg && ctrl.append) begin
            entry_reg <= tok_colour_reg;
        end
    end

    // per-channel absolute difference
    always_comb begin
        dr = (tok_colour_reg.r > entry_reg.r) ? tok_colour_reg.r - entry_reg.r
                                              : entry_reg.r - tok_colour_reg.r;
        dg = (tok_colour_reg.g > entry_reg.g) ? tok_colour_reg.g - entry_reg.g
                                              : entry_reg.g - tok_colour_reg.g;
        db = (tok_colour_reg.b > entry_reg.b) ? tok_colour_reg.b - entry_reg.b
                                              : entry_reg.b - tok_colour_reg.b;
        similar = ({1'b0, dr} < ctrl.threshold) &&
                  ({1'b0, dg} < ctrl.threshold) &&
                  ({1'b0, db} < ctrl.threshold);
    end

    assign hit        = tok_valid_reg & filled & similar;
    assign out_valid  = tok_valid_reg;
    assign out_colour = tok_colour_reg;

endmodule

`default_nettype wire

// ----- rtl/threshold_palette_builder_unit.sv -----
`default_nettype none

// Threshold palette builder. Each request carries one RGB colour; the unit
// keeps a palette of up to PALETTE_DEPTH distinct colours in a row of cells,
// one entry per cell. A colour is similar to an entry when every channel
// differs by less than similarity_threshold (APB register at address 0,
// 9 bits, reset 25). The request walks the cell chain one cell per clock,
// starting at cell 0; it stops at the first similar entry (matched), at the
// first empty cell where it is written in (added), or at the last cell when
// the palette is full (dropped_full). The walk ends at the matching index,
// at the palette count for an append, or at PALETTE_DEPTH-1 for a drop.
// One request is in flight at a time: in_stall stays asserted while it
// walks and falls once the walk finishes, so a new request is taken only
// after the previous walk is over. The result sits in an output register,
// so a new request is taken while an earlier result is still stalled; a
// walk that finishes while that register holds a stalled result waits in
// place until the register can take it.
// clear_first empties the palette at acceptance, before the search. Palette
// contents are not reset; only entries below the count are ever compared.
module threshold_palette_builder_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // APB configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tpb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tpb_pkg::DATA_W-1:0] pwdata,
    output logic      [tpb_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    // request channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [tpb_pkg::CHAN_W-1:0] red,
    input  wire logic [tpb_pkg::CHAN_W-1:0] green,
    input  wire logic [tpb_pkg::CHAN_W-1:0] blue,
    input  wire logic                       clear_first,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            added,
    output logic [tpb_pkg::MATCH_W-1:0]     match_index,
    output logic                            matched,
    output logic                            dropped_full,
    output logic [tpb_pkg::COUNT_W-1:0]     palette_count
);
    import tpb_pkg::*;

    // ---------------- configuration ----------------
    logic [THR_W-1:0] threshold_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_THRESHOLD);
    assign prdata = (paddr[ADDR_W-1:2] == REG_THRESHOLD)
                    ? {{(DATA_W-THR_W){1'b0}}, threshold_reg} : '0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            threshold_reg <= THR_RESET;
        end
        else if (cfg_wr) begin
            threshold_reg <= pwdata[THR_W-1:0];
        end
    end

    // ---------------- controller state ----------------
    logic             busy_reg;
    logic [IDX_W-1:0] pos_reg;     // cell currently holding the request
    logic [CNT_W-1:0] count_reg;   // palette fill

    logic accept;
    logic any_hit;
    logic at_end;                  // request sits on the first empty cell
    logic at_last;
    logic decide;
    logic can_emit;
    logic finish;
    logic do_append;
    logic step;

    logic [PALETTE_DEPTH-1:0] hit_vec;
    logic [PALETTE_DEPTH-1:0] cv_out;
    colour_t                  cc_out [PALETTE_DEPTH];
    cell_ctrl_t               ctrl;
    colour_t                  in_colour;

    assign in_stall  = busy_reg;
    assign accept    = in_valid & ~busy_reg;
    assign in_colour = '{r: red, g: green, b: blue};

    assign any_hit   = |hit_vec;
    assign at_end    = ({{(CNT_W-IDX_W){1'b0}}, pos_reg} == count_reg);
    assign at_last   = (pos_reg == IDX_W'(PALETTE_DEPTH - 1));
    assign decide    = busy_reg & (any_hit | at_end | at_last);
    assign can_emit  = ~out_valid | ~out_stall;
    assign finish    = decide & can_emit;
    assign do_append = finish & ~any_hit & at_end;
    assign step      = busy_reg & ~decide;

    assign ctrl.hold      = decide & ~can_emit;
    assign ctrl.append    = do_append;
    assign ctrl.threshold = threshold_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg  <= 1'b0;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else begin
            if (accept) begin
                busy_reg <= 1'b1;
                pos_reg  <= '0;
                if (clear_first) begin
                    count_reg <= '0;
                end
            end
            else begin
                if (finish) begin
                    busy_reg <= 1'b0;
                end
                if (step) begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (do_append) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
        logic    c_in_valid;
        colour_t c_in_colour;
        logic    c_filled;

        if (i == 0) begin : g_head
            assign c_in_valid  = accept;
            assign c_in_colour = in_colour;
        end
        else begin : g_link
            assign c_in_valid  = cv_out[i-1] & step;
            assign c_in_colour = cc_out[i-1];
        end

        assign c_filled = (CNT_W'(i) < count_reg);

        tpb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .in_valid   (c_in_valid),
            .in_colour  (c_in_colour),
            .filled     (c_filled),
            .out_valid  (cv_out[i]),
            .out_colour (cc_out[i]),
            .hit        (hit_vec[i])
        );
    end

    // ---------------- result register ----------------
    logic               out_valid_reg;
    logic               added_reg;
    logic               matched_reg;
    logic               dropped_reg;
    logic [MATCH_W-1:0] index_reg;
    logic [COUNT_W-1:0] pcount_reg;
    logic [CNT_W-1:0]   count_next;

    assign count_next = count_reg + {{(CNT_W-1){1'b0}}, do_append};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (finish) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (finish) begin
            added_reg   <= do_append;
            matched_reg <= any_hit;
            dropped_reg <= ~any_hit & ~at_end;
            index_reg   <= (any_hit | at_end) ? MATCH_W'(pos_reg) : '0;
            pcount_reg  <= COUNT_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign added         = added_reg;
    assign matched       = matched_reg;
    assign dropped_full  = dropped_reg;
    assign match_index   = index_reg;
    assign palette_count = pcount_reg;

endmodule

`default_nettype wire

// ----- rtl/tpb_checker.sv -----
`default_nettype none

`include "threshold_palette_builder_unit_defines.svh"

module tpb_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic                        added,
    input wire logic [tpb_pkg::MATCH_W-1:0] match_index,
    input wire logic                        matched,
    input wire logic                        dropped_full,
    input wire logic [tpb_pkg::COUNT_W-1:0] palette_count
);
    import tpb_pkg::*;

    // stalled result holds
    `TPB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable({added, matched, dropped_full, match_index, palette_count}),
        "result changed while stalled")

    // exactly one outcome per result
    `TPB_ASSERT_IMP(a_one_outcome, clk, rst_n, out_valid,
        $onehot({added, matched, dropped_full}), "result outcome flags not one-hot")

    // a new entry is the last one in the palette
    `TPB_ASSERT_IMP(a_added_idx, clk, rst_n, out_valid && added,
        MATCH_W'(match_index + 1'b1) == palette_count[MATCH_W-1:0],
        "added index does not match palette count")

    // a drop only happens on a full palette
    `TPB_ASSERT_IMP(a_drop_full, clk, rst_n, out_valid && dropped_full,
        palette_count == COUNT_W'(PALETTE_DEPTH) && match_index == '0,
        "drop reported on a palette that is not full")

    // a match points inside the palette
    `TPB_ASSERT_IMP(a_match_range, clk, rst_n, out_valid && matched,
        COUNT_W'(match_index) < palette_count, "match index beyond palette count")

endmodule

bind threshold_palette_builder_unit tpb_checker u_tpb_checker (.*);

`default_nettype wire
